### hdl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent, both sampled at the clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/sftl_pkg.sv
// ---------------------------------------------------------------------------
// sftl_pkg
// Types and codes of the sorted fault table lookup.
// ---------------------------------------------------------------------------
package sftl_pkg;

    localparam int ADDR_W  = 64;
    localparam int FIXUP_W = 64;
    localparam int INDEX_W = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SORT   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    localparam logic [31:0] WIDEN_MASK = 32'hffff_ffff;

endpackage

### hdl/sftl_if.sv
// ---------------------------------------------------------------------------
// sftl_req_if / sftl_rsp_if
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sftl_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [sftl_pkg::ADDR_W-1:0]   address;
    logic [sftl_pkg::FIXUP_W-1:0]  fixup_word;

    modport source (output valid, op, address, fixup_word, input ready);
    modport sink   (input valid, op, address, fixup_word, output ready);
endinterface

interface sftl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [sftl_pkg::INDEX_W-1:0]  entry_index;
    logic [sftl_pkg::FIXUP_W-1:0]  fixup_out;

    modport source (output valid, status, entry_index, fixup_out, input ready);
    modport sink   (input valid, status, entry_index, fixup_out, output ready);
endinterface

### hdl/sftl_ram.sv
// ---------------------------------------------------------------------------
// sftl_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module sftl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/sorted_fault_table_lookup.sv
// ---------------------------------------------------------------------------
// sorted_fault_table_lookup
// Table of address/fixup pairs with append, sort, binary search and clear.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one transaction: op, address, fixup_word. rsp returns one
//   transaction per request: status, entry_index, fixup_out.
//   One request is worked on at a time; req.ready is high while idle, also
//   while a finished response still waits on rsp.
//   Append and clear go from idle straight to the done state. Search is a
//   binary search that reads the address RAM once per probe and reports
//   a miss when the bounds cross. Sort is an insertion sort through the
//   RAMs. Entries live in two RAMs (address, fixup) with registered read
//   ports; the read port sets the search pace.
//   Reset clears the entry count and all control state; RAM contents are
//   not cleared and are never read above the count.
//   A stalled rsp holds its transaction; the block waits with the next
//   result until rsp is free.
// ---------------------------------------------------------------------------
module sorted_fault_table_lookup #(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    sftl_req_if.sink   req,
    sftl_rsp_if.source rsp
);

    import sftl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_KUSE = 7'b0000010,
        S_PUSE = 7'b0000100,
        S_KPUT = 7'b0001000,
        S_SRD  = 7'b0010000,
        S_SUSE = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic signed [SW-1:0] low_reg, low_next;
    logic signed [SW-1:0] high_reg, high_next;
    logic [AW-1:0]      mid_reg, mid_next;
    logic [ADDR_W-1:0]  key_a_reg, key_a_next;
    logic [FIXUP_W-1:0] key_f_reg, key_f_next;

    logic [1:0]         res_status_reg, res_status_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [FIXUP_W-1:0] res_fixup_reg, res_fixup_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [FIXUP_W-1:0] out_fixup_reg, out_fixup_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [ADDR_W-1:0]  wdata_a;
    logic [FIXUP_W-1:0] wdata_f;
    logic [ADDR_W-1:0]  rdata_a;
    logic [FIXUP_W-1:0] rdata_f;

    logic               accept;
    logic [SW-1:0]      mid_sum;
    logic [CW-1:0]      jm1;
    logic [CW-1:0]      jm2;
    logic [CW-1:0]      ip1;

    sftl_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH), .AW(AW)) u_addr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_a),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    sftl_ram #(.WIDTH(FIXUP_W), .DEPTH(DEPTH), .AW(AW)) u_fixup_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_f),
        .raddr (raddr),
        .rdata (rdata_f)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign accept          = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.fixup_out   = out_fixup_reg;

    assign mid_sum = SW'(unsigned'(low_reg) + unsigned'(high_reg)) >> 1;
    assign jm1     = j_reg - CW'(1);
    assign jm2     = j_reg - CW'(2);
    assign ip1     = i_reg + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        mid_next        = mid_reg;
        key_a_next      = key_a_reg;
        key_f_next      = key_f_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_fixup_next  = res_fixup_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_fixup_next  = out_fixup_reg;
        we              = 1'b0;
        waddr           = count_reg[AW-1:0];
        wdata_a         = req.address;
        wdata_f         = req.fixup_word;
        raddr           = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = '0;
                    res_fixup_next  = '0;
                    state_next      = S_DONE;
                    case (op_t'(req.op))
                        OP_APPEND:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                raddr      = AW'(1);
                                i_next     = CW'(1);
                                j_next     = CW'(1);
                                state_next = S_KUSE;
                            end
                        end
                        OP_SEARCH:
                        begin
                            key_a_next = req.address;
                            if (req.address[63:32] == '0)
                            begin
                                key_a_next[63:32] = WIDEN_MASK;
                            end
                            low_next   = '0;
                            high_next  = signed'(SW'(count_reg)) - SW'(1);
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_KUSE:
            begin
                key_a_next = rdata_a;
                key_f_next = rdata_f;
                raddr      = jm1[AW-1:0];
                state_next = S_PUSE;
            end
            S_PUSE:
            begin
                we      = 1'b1;
                waddr   = j_reg[AW-1:0];
                if (rdata_a > key_a_reg)
                begin
                    wdata_a = rdata_a;
                    wdata_f = rdata_f;
                    j_next  = jm1;
                    if (jm1 == '0)
                    begin
                        state_next = S_KPUT;
                    end
                    else
                    begin
                        raddr = jm2[AW-1:0];
                    end
                end
                else
                begin
                    wdata_a = key_a_reg;
                    wdata_f = key_f_reg;
                    i_next  = ip1;
                    j_next  = ip1;
                    raddr   = ip1[AW-1:0];
                    state_next = (ip1 >= count_reg) ? S_DONE : S_KUSE;
                end
            end
            S_KPUT:
            begin
                we      = 1'b1;
                waddr   = '0;
                wdata_a = key_a_reg;
                wdata_f = key_f_reg;
                i_next  = ip1;
                j_next  = ip1;
                raddr   = ip1[AW-1:0];
                state_next = (ip1 >= count_reg) ? S_DONE : S_KUSE;
            end
            S_SRD:
            begin
                if (low_reg > high_reg)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    raddr      = mid_sum[AW-1:0];
                    mid_next   = mid_sum[AW-1:0];
                    state_next = S_SUSE;
                end
            end
            S_SUSE:
            begin
                if (rdata_a == key_a_reg)
                begin
                    res_status_next = ST_OK;
                    res_index_next  = INDEX_W'(mid_reg);
                    res_fixup_next  = rdata_f;
                    state_next      = S_DONE;
                end
                else if (rdata_a < key_a_reg)
                begin
                    low_next   = signed'(SW'(mid_reg)) + SW'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    high_next  = signed'(SW'(mid_reg)) - SW'(1);
                    state_next = S_SRD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_fixup_next  = res_fixup_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        mid_reg        <= mid_next;
        key_a_reg      <= key_a_next;
        key_f_reg      <= key_f_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_fixup_reg  <= res_fixup_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_fixup_reg  <= out_fixup_next;
    end

endmodule

### hdl/sftl_checker.sv
// ---------------------------------------------------------------------------
// sftl_checker
// Port-level checks of the sorted fault table lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sftl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [7:0]  rsp_entry_index,
    input logic [63:0] rsp_fixup_out
);

    import sftl_pkg::*;

    `ASSERT_ALWAYS(a_status_code, clk, rst_n, !rsp_valid || rsp_status != 2'd3)
    `ASSERT_IMPLIES(a_fixup_only_found, clk, rst_n, rsp_valid && rsp_fixup_out != '0, rsp_status == ST_OK)
    `ASSERT_IMPLIES(a_index_only_found, clk, rst_n, rsp_valid && rsp_entry_index != '0, rsp_status == ST_OK)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

endmodule

bind sorted_fault_table_lookup sftl_checker u_sftl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_index (rsp.entry_index),
    .rsp_fixup_out   (rsp.fixup_out)
);

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted fault table lookup.
// Drives append, sort, search and clear transactions with random gaps and
// response stalls. A scoreboard keeps its own copy of the table, predicts
// each response and compares every field in order.
// ---------------------------------------------------------------------------
import sftl_pkg::*;

typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] entry_index;
    logic [FIXUP_W-1:0] fixup_out;
} lookup_rsp_t;

class fault_table_scoreboard;
    localparam int TABLE_DEPTH = 256;

    logic [ADDR_W-1:0]  tbl_addr [TABLE_DEPTH];
    logic [FIXUP_W-1:0] tbl_fixup [TABLE_DEPTH];
    int                 tbl_count;
    lookup_rsp_t        expected_rsps [$];
    int                 mismatches;
    int                 checked;
    int                 hits;

    function new();
        tbl_count   = 0;
        mismatches  = 0;
        checked     = 0;
        hits        = 0;
    endfunction

    function void sort_table();
        logic [ADDR_W-1:0]  ka;
        logic [FIXUP_W-1:0] kf;
        int                 j;
        for (int i = 1; i < tbl_count; i++) begin
            ka = tbl_addr[i];
            kf = tbl_fixup[i];
            j  = i;
            while (j > 0 && tbl_addr[j-1] > ka) begin
                tbl_addr[j]  = tbl_addr[j-1];
                tbl_fixup[j] = tbl_fixup[j-1];
                j--;
            end
            tbl_addr[j]  = ka;
            tbl_fixup[j] = kf;
        end
    endfunction

    function void note_request(op_t op, logic [ADDR_W-1:0] address,
                               logic [FIXUP_W-1:0] fixup_word);
        lookup_rsp_t       r;
        logic [ADDR_W-1:0] key;
        int                lo;
        int                hi;
        int                mid;
        r = '{ST_OK, '0, '0};
        case (op)
            OP_APPEND:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    tbl_addr[tbl_count]  = address;
                    tbl_fixup[tbl_count] = fixup_word;
                    tbl_count++;
                end
            end
            OP_SORT:
                sort_table();
            OP_SEARCH:
            begin
                key = address;
                if (key[63:32] == 32'd0)
                    key[63:32] = WIDEN_MASK;
                lo = 0;
                hi = tbl_count - 1;
                r.status = ST_NOTFOUND;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_addr[mid] == key)
                    begin
                        r.status      = ST_OK;
                        r.entry_index = mid[7:0];
                        r.fixup_out   = tbl_fixup[mid];
                        break;
                    end
                    if (tbl_addr[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            default:
                tbl_count = 0;
        endcase
        expected_rsps.push_back(r);
    endfunction

    function void check_response(lookup_rsp_t got);
        lookup_rsp_t exp_r;
        checked++;
        if (expected_rsps.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected response status=%0d index=%0d fixup=%h",
                         got.status, got.entry_index, got.fixup_out);
            return;
        end
        exp_r = expected_rsps.pop_front();
        if (exp_r.status == ST_OK && exp_r.fixup_out != 0)
            hits++;
        if (got.status !== exp_r.status || got.entry_index !== exp_r.entry_index ||
            got.fixup_out !== exp_r.fixup_out)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: response %0d: exp status=%0d index=%0d fixup=%h, got status=%0d index=%0d fixup=%h",
                         checked, exp_r.status, exp_r.entry_index, exp_r.fixup_out,
                         got.status, got.entry_index, got.fixup_out);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS  = 1100;
    localparam int IDLE_LIMIT = 200000;
    localparam int LONG_HOLD  = 300;

    logic clk;
    logic rst_n;

    sftl_req_if req_ch ();
    sftl_rsp_if rsp_ch ();

    sorted_fault_table_lookup #(.DEPTH(256)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fault_table_scoreboard sb = new();

    int                items_sent;
    bit                no_gaps;
    bit                hold_rsp;
    int                idle_cycles;
    logic [ADDR_W-1:0] loaded [$];
    logic [ADDR_W-1:0] dup_pool [4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // response side
    initial
    begin
        int stall;
        lookup_rsp_t got;
        bit held;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_rsp && !held)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.status      = status_t'(rsp_ch.status);
            got.entry_index = rsp_ch.entry_index;
            got.fixup_out   = rsp_ch.fixup_out;
            sb.check_response(got);
        end
    end

    task automatic send_item(op_t op, logic [ADDR_W-1:0] address,
                             logic [FIXUP_W-1:0] fixup_word);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.address    <= address;
        req_ch.fixup_word <= fixup_word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, address, fixup_word);
        items_sent++;
        if (op == OP_APPEND)
            loaded.push_back(address);
        else if (op == OP_CLEAR)
            loaded.delete();
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return {32'd0, $urandom};
            2: return {WIDEN_MASK, $urandom};
            3: return dup_pool[$urandom_range(0, 3)];
            4: return $urandom_range(0, 1) ? '0 : '1;
            default: return {WIDEN_MASK, 16'd0, 16'($urandom_range(0, 63))};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_key();
        logic [ADDR_W-1:0] k;
        if (loaded.size() != 0 && $urandom_range(0, 9) < 7)
        begin
            k = loaded[$urandom_range(0, loaded.size() - 1)];
            if (k[63:32] == WIDEN_MASK && $urandom_range(0, 1))
                k[63:32] = 32'd0;
            return k;
        end
        return pick_address();
    endfunction

    task automatic table_round(int n);
        bit sorted_first;
        send_item(OP_CLEAR, rand64(), rand64());
        for (int i = 0; i < n; i++)
            send_item(OP_APPEND, pick_address(), rand64());
        sorted_first = $urandom_range(0, 9) != 0;
        if (!sorted_first)
            repeat ($urandom_range(1, 3)) send_item(OP_SEARCH, pick_key(), rand64());
        send_item(OP_SORT, rand64(), rand64());
        repeat ($urandom_range(2, 10)) begin
            if ($urandom_range(0, 15) == 0)
                send_item(op_t'($urandom_range(0, 3)), pick_address(), rand64());
            else
                send_item(OP_SEARCH, pick_key(), rand64());
        end
    endtask

    initial
    begin
        int round_cnt;
        req_ch.valid      = 1'b0;
        req_ch.op         = '0;
        req_ch.address    = '0;
        req_ch.fixup_word = '0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        hold_rsp    = 1'b0;
        round_cnt   = 0;
        for (int i = 0; i < 4; i++)
            dup_pool[i] = {WIDEN_MASK, $urandom};
        @(posedge rst_n);
        @(posedge clk);

        // directed
        send_item(OP_SEARCH, 64'h0, 64'h0);
        send_item(OP_SORT, '1, '1);
        send_item(OP_APPEND, 64'hffff_ffff_0000_1000, 64'h1111);
        send_item(OP_APPEND, '1, '1);
        send_item(OP_APPEND, 64'h0, 64'h0);
        send_item(OP_APPEND, 64'h0000_0000_0000_1000, 64'h2222);
        send_item(OP_APPEND, 64'hffff_ffff_0000_1000, 64'h3333);
        send_item(OP_APPEND, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_item(OP_SEARCH, 64'h0000_0000_0000_1000, 64'h0);
        send_item(OP_SORT, 64'h0, 64'h0);
        send_item(OP_SEARCH, 64'h0000_0000_0000_1000, '1);
        send_item(OP_SEARCH, 64'hffff_ffff_0000_1000, 64'h0);
        send_item(OP_SEARCH, '1, 64'h0);
        send_item(OP_SEARCH, 64'h0, 64'h0);
        send_item(OP_SEARCH, 64'h8000_0000_0000_0000, 64'h0);
        send_item(OP_SEARCH, 64'h1234_5678_9abc_def0, 64'h0);
        send_item(OP_CLEAR, '1, '1);
        send_item(OP_SEARCH, '1, '1);
        send_item(OP_APPEND, 64'h5555_5555_aaaa_aaaa, 64'haaaa_aaaa_5555_5555);
        send_item(OP_SEARCH, 64'h5555_5555_aaaa_aaaa, 64'h0);
        drain_results();

        // fill past capacity, with a long response hold while the table fills
        hold_rsp = 1'b1;
        table_round(258);
        drain_results();

        while (items_sent < NUM_ITEMS) begin
            round_cnt++;
            no_gaps = $urandom_range(0, 5) == 0;
            if (round_cnt % 40 == 0)
                table_round($urandom_range(200, 258));
            else
                table_round($urandom_range(0, 16));
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        no_gaps = 1'b0;
        drain_results();
        repeat (40) @(posedge clk);

        $display("covered %0d transactions, %0d responses checked, %0d search hits",
                 items_sent, sb.checked, sb.hits);
        $display("mismatches: %0d, leftover expectations: %0d",
                 sb.mismatches, sb.expected_rsps.size());
        if (sb.mismatches == 0 && sb.expected_rsps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
